>>> rtl/q4k_pkg.sv
// shared types, fp32 arithmetic helpers and constants for the q4k row dot unit
// depends on nothing; used by q4k_ctrl, q4k_datapath and the top level
package q4k_pkg;

    localparam int unsigned InBits   = 480;
    localparam int unsigned DotBits  = 17;
    localparam logic [31:0] Fp32Qnan = 32'h7FC0_0000;

    // one-hot step commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic dot;
        logic mul1;
        logic mul2;
        logic sub;
        logic acc;
    } cmd_t;

    // status back to the controller
    typedef struct packed {
        logic last;
        logic out_busy;
    } stat_t;

    function automatic logic [5:0] lzc50(input logic [49:0] m);
        logic [5:0] n;
        logic       found;
        n     = 6'd50;
        found = 1'b0;
        for (int i = 49; i >= 0; i--)
        begin
            if (!found && m[i])
            begin
                n     = 6'(49 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    // value = m * 2^(ex - 127 - 48); round to nearest even, keep subnormals
    function automatic logic [31:0] fp_round(input logic sgn, input logic signed [11:0] ex,
                                             input logic [49:0] m);
        logic [5:0]         lz;
        logic signed [11:0] e;
        logic [49:0]        mn;
        logic [11:0]        sh;
        logic               sticky;
        logic [24:0]        sig;
        logic               rnd;
        logic [7:0]         ef;
        if (m == 50'd0)
        begin
            return {sgn, 31'd0};
        end
        lz = lzc50(m);
        mn = m << lz;
        e  = ex + 12'sd1 - $signed({6'd0, lz});
        if (e < 12'sd1)
        begin
            sh = 12'(12'sd1 - e);
            if (sh > 12'd49)
            begin
                sticky = |mn;
                mn     = {49'd0, sticky};
            end
            else
            begin
                sticky = |(mn & ((50'd1 << sh) - 50'd1));
                mn     = (mn >> sh) | {49'd0, sticky};
            end
            e = 12'sd1;
        end
        sig = {1'b0, mn[49:26]};
        rnd = mn[25] & ((|mn[24:0]) | mn[26]);
        sig = sig + {24'd0, rnd};
        if (sig[24])
        begin
            sig = sig >> 1;
            e   = e + 12'sd1;
        end
        if (e >= 12'sd255)
        begin
            return {sgn, 8'hFF, 23'd0};
        end
        ef = sig[23] ? e[7:0] : 8'd0;
        return {sgn, ef, sig[22:0]};
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic               s;
        logic               nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
        logic [7:0]         xa, xb;
        logic [23:0]        ma, mb;
        logic [47:0]        p;
        logic signed [11:0] ex;
        s      = a[31] ^ b[31];
        nan_a  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        nan_b  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        inf_a  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        inf_b  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        zero_a = a[30:0] == 31'd0;
        zero_b = b[30:0] == 31'd0;
        if (nan_a || nan_b || (inf_a && zero_b) || (inf_b && zero_a))
        begin
            return Fp32Qnan;
        end
        if (inf_a || inf_b)
        begin
            return {s, 8'hFF, 23'd0};
        end
        xa = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        xb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma = {a[30:23] != 8'd0, a[22:0]};
        mb = {b[30:23] != 8'd0, b[22:0]};
        p  = ma * mb;
        ex = $signed({4'd0, xa}) + $signed({4'd0, xb}) - 12'sd127;
        return fp_round(s, ex, {p, 2'b00});
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic        nan_a, nan_b, inf_a, inf_b;
        logic [31:0] big, sml;
        logic [7:0]  xbig, xsml, d;
        logic [49:0] mbig, msml, msh, sum;
        logic        sticky;
        nan_a = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        nan_b = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        inf_a = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        inf_b = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        if (nan_a || nan_b || (inf_a && inf_b && (a[31] != b[31])))
        begin
            return Fp32Qnan;
        end
        if (inf_a)
        begin
            return a;
        end
        if (inf_b)
        begin
            return b;
        end
        big  = (a[30:0] >= b[30:0]) ? a : b;
        sml  = (a[30:0] >= b[30:0]) ? b : a;
        xbig = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        xsml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        mbig = {1'b0, big[30:23] != 8'd0, big[22:0], 25'd0};
        msml = {1'b0, sml[30:23] != 8'd0, sml[22:0], 25'd0};
        d    = xbig - xsml;
        if (d > 8'd49)
        begin
            msh = {49'd0, |msml};
        end
        else
        begin
            sticky = |(msml & ((50'd1 << d) - 50'd1));
            msh    = (msml >> d) | {49'd0, sticky};
        end
        sum = (big[31] == sml[31]) ? (mbig + msh) : (mbig - msh);
        if (sum == 50'd0)
        begin
            return {a[31] & b[31], 31'd0};
        end
        return fp_round(big[31], $signed({4'd0, xbig}), sum);
    endfunction

    function automatic logic [31:0] fp_sub(input logic [31:0] a, input logic [31:0] b);
        return fp_add(a, {~b[31], b[30:0]});
    endfunction

    // small integer to fp32, always exact
    function automatic logic [31:0] int_to_fp(input logic signed [DotBits-1:0] v);
        logic [DotBits-1:0] mag;
        mag = v[DotBits-1] ? (~v + 1'b1) : v;
        return fp_round(v[DotBits-1], 12'sd175, {{(50-DotBits){1'b0}}, mag});
    endfunction

    function automatic logic [31:0] half_to_fp(input logic [15:0] h);
        if (h[14:10] == 5'h1F)
        begin
            return {h[15], 8'hFF, h[9:0], 13'd0};
        end
        if (h[14:10] == 5'd0)
        begin
            return fp_round(h[15], 12'sd151, {40'd0, h[9:0]});
        end
        return fp_round(h[15], $signed({7'd0, h[14:10]}) + 12'sd150, {39'd0, 1'b1, h[9:0]});
    endfunction

endpackage

>>> rtl/q4k_ctrl.sv
// step sequencer for the q4k row dot unit
// depends on q4k_pkg (cmd_t, stat_t)
module q4k_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  q4k_pkg::stat_t stat,
    output q4k_pkg::cmd_t  cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DOT  = 3'd1;
    localparam logic [2:0] S_MUL1 = 3'd2;
    localparam logic [2:0] S_MUL2 = 3'd3;
    localparam logic [2:0] S_SUB  = 3'd4;
    localparam logic [2:0] S_ACC  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       acc_go;

    assign in_ready = state_reg == S_IDLE;
    // hold the accumulate while a row total would overwrite an untaken word
    assign acc_go   = (state_reg == S_ACC) && !(stat.last && stat.out_busy);

    always_comb
    begin
        cmd.load = (state_reg == S_IDLE) && in_valid;
        cmd.dot  = state_reg == S_DOT;
        cmd.mul1 = state_reg == S_MUL1;
        cmd.mul2 = state_reg == S_MUL2;
        cmd.sub  = state_reg == S_SUB;
        cmd.acc  = acc_go;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  state_next = in_valid ? S_DOT : S_IDLE;
            S_DOT:   state_next = S_MUL1;
            S_MUL1:  state_next = S_MUL2;
            S_MUL2:  state_next = S_SUB;
            S_SUB:   state_next = S_ACC;
            S_ACC:   state_next = acc_go ? S_IDLE : S_ACC;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.dot, cmd.mul1, cmd.mul2, cmd.sub, cmd.acc}))
        else $error("more than one step command");
    a_load_dot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.dot)
        else $error("load not followed by dot step");
    a_sub_acc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sub |=> (state_reg == S_ACC))
        else $error("subtract not followed by accumulate");
    a_acc_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc |=> in_ready)
        else $error("accumulate did not return to idle");

endmodule

>>> rtl/q4k_datapath.sv
// operand registers, integer dot, fp32 multiply/add steps and row accumulator
// depends on q4k_pkg (cmd_t, stat_t, fp helpers)
module q4k_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  q4k_pkg::cmd_t                cmd,
    output q4k_pkg::stat_t               stat,
    input  logic [q4k_pkg::InBits-1:0]   in_data,
    input  logic                         in_last,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [31:0]                  out_data
);

    logic [127:0] nib_reg;
    logic [255:0] act_reg;
    logic [15:0]  wsc_h_reg, woff_h_reg;
    logic [31:0]  asc_reg, asum_reg;
    logic         last_reg;
    logic signed [q4k_pkg::DotBits-1:0] dot_reg, dot_next;
    logic [31:0]  wsc_reg, woff_reg, scale_reg, offs_reg, fdot_reg, prod_reg, term_reg;
    logic [31:0]  acc_reg, acc_next;
    logic         out_valid_reg;
    logic [31:0]  out_data_reg;
    logic [7:0]   nb;
    logic signed [12:0] p_lo, p_hi;

    // 32 nibble by int8 products summed into a 17-bit signed dot
    always_comb
    begin
        dot_next = '0;
        nb       = '0;
        p_lo     = '0;
        p_hi     = '0;
        for (int b = 0; b < 16; b++)
        begin
            nb       = nib_reg[8*b +: 8];
            p_lo     = $signed({1'b0, nb[3:0]}) * $signed(act_reg[8*b +: 8]);
            p_hi     = $signed({1'b0, nb[7:4]}) * $signed(act_reg[8*(b+16) +: 8]);
            dot_next = dot_next + {{4{p_lo[12]}}, p_lo} + {{4{p_hi[12]}}, p_hi};
        end
    end

    assign acc_next = q4k_pkg::fp_add(acc_reg, term_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            nib_reg    <= in_data[127:0];
            act_reg    <= in_data[383:128];
            wsc_h_reg  <= in_data[399:384];
            woff_h_reg <= in_data[415:400];
            asc_reg    <= in_data[447:416];
            asum_reg   <= in_data[479:448];
            last_reg   <= in_last;
        end
        if (cmd.dot)
        begin
            dot_reg  <= dot_next;
            wsc_reg  <= q4k_pkg::half_to_fp(wsc_h_reg);
            woff_reg <= q4k_pkg::half_to_fp(woff_h_reg);
        end
        if (cmd.mul1)
        begin
            scale_reg <= q4k_pkg::fp_mul(wsc_reg, asc_reg);
            offs_reg  <= q4k_pkg::fp_mul(woff_reg, asum_reg);
            fdot_reg  <= q4k_pkg::int_to_fp(dot_reg);
        end
        if (cmd.mul2)
        begin
            prod_reg <= q4k_pkg::fp_mul(scale_reg, fdot_reg);
        end
        if (cmd.sub)
        begin
            term_reg <= q4k_pkg::fp_sub(prod_reg, offs_reg);
        end
        if (cmd.acc && last_reg)
        begin
            out_data_reg <= ((acc_next[30:23] == 8'hFF) && (acc_next[22:0] != 23'd0)) ?
                            q4k_pkg::Fp32Qnan : acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.acc)
            begin
                acc_reg <= last_reg ? 32'd0 : acc_next;
            end
            if (cmd.acc && last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.last     = last_reg;
    assign stat.out_busy = out_valid_reg && !out_ready;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;

endmodule

>>> rtl/q4k_int8_row_dot_accumulate_unit.sv
// top level of the q4k x int8 row dot accumulate unit
// depends on q4k_pkg, q4k_ctrl, q4k_datapath
//
// channel | dir | bits            | contents
// s_*     | in  | tdata 480, last | one 32-weight sub-block word, tlast ends the row
// m_*     | out | tdata 32        | fp32 row total, one word per row
//
// an input word goes through accept, integer dot, two parallel multiplies,
// dot scale multiply, subtract, accumulate; only one word is in flight, so the
// five serial steps after the accept set the rate
// a row total sits in the output register while the next word is accepted
// the last word of a row waits in the accumulate step while the previous total is untaken
// reset clears the sequencer, the accumulator (to +0.0) and the output valid
module q4k_int8_row_dot_accumulate_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // nibbles_low_half, nibbles_high_half, acts_0_to_7, acts_8_to_15, acts_16_to_23,
    // acts_24_to_31, weight_scale, weight_offset, act_scale, act_sum
    input  logic [479:0] s_tdata,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // row_value
    output logic [31:0]  m_tdata
);

    q4k_pkg::cmd_t  cmd;
    q4k_pkg::stat_t stat;

    // sequencer: steps one word through the datapath
    q4k_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: operand regs, fp32 units, accumulator and output register
    q4k_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (s_tdata),
        .in_last   (s_tlast),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

>>> tb/sv/q4k_int8_row_dot_accumulate_unit_test.sv
// self-checking bench for the q4k x int8 row dot accumulate unit
// depends on q4k_int8_row_dot_accumulate_unit and its rtl; holds its own fp32 row predictor
`timescale 1ns / 100ps

// predicts row totals from accepted sub-block words and checks the row words that come out
class row_dot_scoreboard;
    logic [31:0] row_total;
    logic [31:0] pending_rows[$];
    int          mismatches;

    function new();
        row_total  = 32'd0;
        mismatches = 0;
    endfunction

    // value = m * 2^lsb_e, rounded to nearest even, subnormals kept
    static function logic [31:0] round_pack(bit s, int lsb_e, logic [79:0] m);
        int          p;
        int          sh;
        logic [79:0] q;
        bit          g;
        bit          st;
        if (m == 80'd0)
        begin
            return {s, 31'd0};
        end
        p = 79;
        while (!m[p])
        begin
            p--;
        end
        sh = p - 23;
        if (sh < -149 - lsb_e)
        begin
            sh = -149 - lsb_e;
        end
        if (sh > 79)
        begin
            q = 80'd0;
        end
        else if (sh > 0)
        begin
            q  = m >> sh;
            g  = m[sh-1];
            st = (sh > 1) ? |(m & ((80'd1 << (sh - 1)) - 80'd1)) : 1'b0;
            if (g && (st || q[0]))
            begin
                q = q + 80'd1;
            end
        end
        else
        begin
            q = m << (-sh);
        end
        lsb_e += sh;
        if (q[24])
        begin
            q = q >> 1;
            lsb_e++;
        end
        if (q[23])
        begin
            if (lsb_e + 150 >= 255)
            begin
                return {s, 8'hFF, 23'd0};
            end
            return {s, 8'(lsb_e + 150), q[22:0]};
        end
        return {s, 8'd0, q[22:0]};
    endfunction

    static function bit is_nan(logic [31:0] f);
        return (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
    endfunction

    static function bit is_inf(logic [31:0] f);
        return (f[30:23] == 8'hFF) && (f[22:0] == 23'd0);
    endfunction

    static function int lsb_exp(logic [31:0] f);
        return ((f[30:23] == 8'd0) ? 1 : int'(f[30:23])) - 150;
    endfunction

    static function logic [79:0] sig_of(logic [31:0] f);
        return {56'd0, f[30:23] != 8'd0, f[22:0]};
    endfunction

    static function logic [31:0] f32_mul(logic [31:0] a, logic [31:0] b);
        bit s;
        s = a[31] ^ b[31];
        if (is_nan(a) || is_nan(b) || (is_inf(a) && b[30:0] == 0) || (is_inf(b) && a[30:0] == 0))
        begin
            return 32'h7FC0_0000;
        end
        if (is_inf(a) || is_inf(b))
        begin
            return {s, 8'hFF, 23'd0};
        end
        return round_pack(s, lsb_exp(a) + lsb_exp(b), sig_of(a) * sig_of(b));
    endfunction

    static function logic [31:0] f32_add(logic [31:0] a, logic [31:0] b);
        logic [31:0] hi;
        logic [31:0] lo;
        logic [79:0] wa;
        logic [79:0] wb;
        int          d;
        if (is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b) && a[31] != b[31]))
        begin
            return 32'h7FC0_0000;
        end
        if (is_inf(a))
        begin
            return a;
        end
        if (is_inf(b))
        begin
            return b;
        end
        if (a[30:0] == 0 && b[30:0] == 0)
        begin
            return {a[31] & b[31], 31'd0};
        end
        hi = (lsb_exp(a) >= lsb_exp(b)) ? a : b;
        lo = (lsb_exp(a) >= lsb_exp(b)) ? b : a;
        d  = lsb_exp(hi) - lsb_exp(lo);
        wa = sig_of(hi) << 40;
        if (d <= 40)
        begin
            wb = sig_of(lo) << (40 - d);
        end
        else
        begin
            // far below the rounding point, a sticky bit is all that matters
            wb = {79'd0, sig_of(lo) != 0};
        end
        if (hi[31] == lo[31])
        begin
            return round_pack(hi[31], lsb_exp(hi) - 40, wa + wb);
        end
        if (wa == wb)
        begin
            return 32'd0;
        end
        if (wa > wb)
        begin
            return round_pack(hi[31], lsb_exp(hi) - 40, wa - wb);
        end
        return round_pack(lo[31], lsb_exp(hi) - 40, wb - wa);
    endfunction

    static function logic [31:0] half_widen(logic [15:0] h);
        if (h[14:10] == 5'h1F)
        begin
            return {h[15], 8'hFF, h[9:0], 13'd0};
        end
        return round_pack(h[15], ((h[14:10] == 0) ? 1 : int'(h[14:10])) - 25,
                          {69'd0, h[14:10] != 0, h[9:0]});
    endfunction

    // notes one accepted sub-block word and queues the row total on the last one
    function void note_sub_block(logic [479:0] w, bit last_mark);
        int          dot;
        int          nib;
        logic [31:0] term;
        logic [31:0] scale;
        dot = 0;
        for (int b = 0; b < 16; b++)
        begin
            nib = w[8*b +: 4];
            dot += nib * int'($signed(w[128 + 8*b +: 8]));
            nib = w[8*b + 4 +: 4];
            dot += nib * int'($signed(w[256 + 8*b +: 8]));
        end
        scale = f32_mul(half_widen(w[399:384]), w[447:416]);
        term  = f32_mul(scale, round_pack(dot < 0, 0, 80'(dot < 0 ? -dot : dot)));
        term  = f32_add(term, f32_mul(half_widen(w[415:400]), w[479:448]) ^ 32'h8000_0000);
        row_total = f32_add(row_total, term);
        if (last_mark)
        begin
            pending_rows.push_back(is_nan(row_total) ? 32'h7FC0_0000 : row_total);
            row_total = 32'd0;
        end
    endfunction

    function void check_row(logic [31:0] got);
        logic [31:0] want;
        if (pending_rows.size() == 0)
        begin
            $error("row_value: no row expected, actual %h", got);
            mismatches++;
            return;
        end
        want = pending_rows.pop_front();
        if (got !== want)
        begin
            $error("row_value: expected %h, actual %h", want, got);
            mismatches++;
        end
    endfunction
endclass

module q4k_int8_row_dot_accumulate_unit_test;
    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    // nibbles_low_half, nibbles_high_half, acts_0_to_7, acts_8_to_15, acts_16_to_23,
    // acts_24_to_31, weight_scale, weight_offset, act_scale, act_sum
    logic [479:0] s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    // row_value
    logic [31:0]  m_tdata;

    row_dot_scoreboard rows;
    int  words_sent;
    bit  quiet_tail;      // no idling in the last part of the run
    bit  stimulus_done;
    int  idle_cycles;

    q4k_int8_row_dot_accumulate_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // mostly tame fp32 values so row totals stay meaningful, now and then raw bits
    function automatic logic [31:0] some_f32();
        if ($urandom_range(0, 99) < 4)
        begin
            return $urandom;
        end
        return {1'($urandom), 8'($urandom_range(107, 147)), 23'($urandom)};
    endfunction

    function automatic logic [15:0] some_f16();
        if ($urandom_range(0, 99) < 4)
        begin
            return 16'($urandom);
        end
        return {1'($urandom), 5'($urandom_range(3, 22)), 10'($urandom)};
    endfunction

    function automatic logic [479:0] random_word();
        logic [479:0] w;
        for (int i = 0; i < 12; i++)
        begin
            w[32*i +: 32] = $urandom;
        end
        w[399:384] = some_f16();
        w[415:400] = some_f16();
        w[447:416] = some_f32();
        w[479:448] = some_f32();
        return w;
    endfunction

    function automatic logic [479:0] make_word(logic [63:0] nib, logic [63:0] act,
                                               logic [15:0] wsc, logic [15:0] woff,
                                               logic [31:0] asc, logic [31:0] asum);
        return {asum, asc, woff, wsc, act, act, act, act, nib, nib};
    endfunction

    // offers one word, holding it until the block takes it
    task automatic send_word(logic [479:0] w, bit last_mark);
        if (!quiet_tail && $urandom_range(0, 5) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = w;
        s_tlast  = last_mark;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        @(negedge clk);
        s_tvalid = 1'b0;
        words_sent++;
        if (words_sent > 1700)
        begin
            quiet_tail = 1'b1;
        end
    endtask

    // accepted words feed the predictor, accepted row words are checked
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            rows.note_sub_block(s_tdata, s_tlast);
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            rows.check_row(m_tdata);
        end
    end

    // receiver: one long hold-off early so the block backs up, then random stall bursts
    initial
    begin
        m_tready = 1'b0;
        wait (rst_n);
        repeat (300) @(negedge clk);
        forever
        begin
            m_tready = 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge clk);
            if (!quiet_tail && $urandom_range(0, 2) == 0)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= 3000)
        begin
            $display("q4k_int8_row_dot_accumulate_unit_test NOT OK");
            $finish;
        end
    end

    initial
    begin
        int row_len;
        rows          = new();
        words_sent    = 0;
        quiet_tail    = 1'b0;
        stimulus_done = 1'b0;
        idle_cycles   = 0;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: field extremes and the special cases
        // largest positive and negative dots, exact zero
        send_word(make_word({64{1'b1}}, {8{8'h7F}}, 16'h3C00, 16'h0000, 32'h3F80_0000,
                            32'h0), 1'b1);
        send_word(make_word({64{1'b1}}, {8{8'h80}}, 16'h3C00, 16'h3C00, 32'h3F80_0000,
                            32'h3F80_0000), 1'b1);
        send_word(make_word(64'd0, 64'd0, 16'h0000, 16'h8000, 32'h0, 32'h8000_0000), 1'b1);
        // a row spread over several words, no last mark until the end
        send_word(make_word(64'h0123_4567_89AB_CDEF, 64'h80FF_017F_10F0_2233, 16'h2E66,
                            16'h1800, 32'h3C00_0000, 32'hC2C8_0000), 1'b0);
        send_word(make_word(64'hFEDC_BA98_7654_3210, 64'h7F01_FF80_EE12_3456, 16'hB266,
                            16'h9A00, 32'h3B80_0000, 32'h4348_0000), 1'b0);
        send_word(make_word(64'h5A5A_A5A5_0F0F_F0F0, 64'hC3C3_3C3C_1111_EEEE, 16'h3555,
                            16'h0001, 32'h3E00_0000, 32'h4120_0000), 1'b1);
        // subnormal halves and fp32 subnormals, subnormal results
        send_word(make_word(64'h1111_1111_1111_1111, 64'h0101_0101_0101_0101, 16'h0001,
                            16'h83FF, 32'h0000_0001, 32'h007F_FFFF), 1'b1);
        send_word(make_word(64'h2222_2222_2222_2222, 64'h0303_0303_0303_0303, 16'h03FF,
                            16'h0200, 32'h0080_0000, 32'h8000_0003), 1'b1);
        // overflow to infinity, then infinity minus infinity
        send_word(make_word({64{1'b1}}, {8{8'h7F}}, 16'h7BFF, 16'h0000, 32'h7F7F_FFFF,
                            32'h0), 1'b1);
        send_word(make_word(64'h0, 64'h0, 16'h7C00, 16'h3C00, 32'h3F80_0000,
                            32'h7F80_0000), 1'b1);
        send_word(make_word(64'h1, 64'h1, 16'h7C00, 16'h3C00, 32'h3F80_0000,
                            32'h7F80_0000), 1'b1);
        // nan from halves and from fp32 inputs, a row continuing after a nan
        send_word(make_word(64'h1, 64'h1, 16'h7E01, 16'h0, 32'h3F80_0000, 32'h0), 1'b0);
        send_word(make_word(64'h1, 64'h1, 16'h3C00, 16'h0, 32'h3F80_0000, 32'h0), 1'b1);
        send_word(make_word(64'h1, 64'h1, 16'h3C00, 16'hFFFF, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF), 1'b1);
        send_word(make_word(64'h1, 64'h1, 16'hFC00, 16'h0, 32'h7F80_0000, 32'h0), 1'b1);
        // opposite terms cancel to zero
        send_word(make_word(64'h1, 64'h1, 16'h3C00, 16'h3C00, 32'h3F80_0000,
                            32'h4000_0000), 1'b1);
        // all ones everywhere
        send_word({480{1'b1}}, 1'b1);

        // random rows, mostly short
        while (words_sent < 1900)
        begin
            row_len = $urandom_range(1, 6);
            for (int i = 0; i < row_len; i++)
            begin
                send_word(random_word(), i == row_len - 1);
            end
        end
        stimulus_done = 1'b1;

        while (rows.pending_rows.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (20) @(negedge clk);
        if (rows.mismatches == 0)
        begin
            $display("q4k_int8_row_dot_accumulate_unit_test OK");
        end
        else
        begin
            $display("q4k_int8_row_dot_accumulate_unit_test NOT OK");
        end
        $finish;
    end
endmodule

>>> filelist.f
rtl/q4k_pkg.sv
rtl/q4k_ctrl.sv
rtl/q4k_datapath.sv
rtl/q4k_int8_row_dot_accumulate_unit.sv
tb/sv/q4k_int8_row_dot_accumulate_unit_test.sv
